[rtl/dual_motor_ramp_pwm_duty_top_defines.svh]
// assertion macros shared by the dual motor ramp design
`ifndef DUAL_MOTOR_RAMP_PWM_DUTY_TOP_DEFINES_SVH
`define DUAL_MOTOR_RAMP_PWM_DUTY_TOP_DEFINES_SVH

// clocked assertion, disabled while reset is asserted
`define DMRP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// same-cycle implication
`define DMRP_ASSERT_IMP(lbl, ante, cons, msg) \
  `DMRP_ASSERT(lbl, (ante) |-> (cons), msg)

// next-cycle implication
`define DMRP_ASSERT_NXT(lbl, ante, cons, msg) \
  `DMRP_ASSERT(lbl, (ante) |=> (cons), msg)

`endif

[rtl/dmrp_pkg.sv]
// shared types and constants for the dual motor ramp and duty block
`default_nettype none

package dmrp_pkg;

  // field widths
  localparam int SPEED_W  = 15;
  localparam int RAMP_W   = 14;
  localparam int OFFSET_W = 11;
  localparam int DUTY_W   = 12;
  localparam int MAG_W    = 14;
  localparam int CFG_W    = 14;

  // limits and reset values
  localparam logic signed [SPEED_W-1:0] SPEED_LIMIT = 15'sd10000;
  localparam logic [DUTY_W-1:0]   DUTY_MAX     = 12'd4095;
  localparam logic [RAMP_W-1:0]   RAMP_RESET   = 14'd60;
  localparam logic [OFFSET_W-1:0] OFFSET_RESET = 11'd50;

  // duty scale default and fixed-point shift for the divide by 100
  localparam int DUTY_SCALE_DEF = 24;
  localparam int RECIP_SHIFT    = 20;

  // item operation codes
  typedef enum logic {
    OP_TICK = 1'b0,
    OP_SET  = 1'b1
  } dmrp_op_e;

  // motor selection
  typedef enum logic {
    MOTOR_RIGHT = 1'b0,
    MOTOR_LEFT  = 1'b1
  } dmrp_motor_e;

  // configuration register indexes
  typedef enum logic {
    REG_RAMP_STEP = 1'b0,
    REG_DEADBAND  = 1'b1
  } dmrp_reg_e;

  // per-motor control strobes
  typedef struct packed {
    logic set_en;
    logic tick_en;
  } dmrp_ctrl_t;

endpackage

`default_nettype wire

[rtl/dual_motor_ramp_pwm_duty_top.sv]
// Dual motor slew-limited ramp with bipolar PWM duty outputs.
// A tick item passes the input register, then its result loads into the result register.
// Throughput: one item per cycle unless a tick item must wait on an untaken result.
// Set items update the target store and give no result.
// Reset (async, active low): ramp_step 60, deadband_offset 50, all stores zero, pipe empty.
`default_nettype none
`include "dual_motor_ramp_pwm_duty_top_defines.svh"

module dual_motor_ramp_pwm_duty_top
  import dmrp_pkg::*;
#(
  parameter int DUTY_SCALE = DUTY_SCALE_DEF
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  // configuration write port
  input  wire logic                      cfg_we_i,
  input  wire logic                      cfg_index_i,
  input  wire logic [CFG_W-1:0]          cfg_data_i,
  // input items
  input  wire logic                      in_valid_i,
  output logic                           in_ready_o,
  input  wire logic                      operation_i,
  input  wire logic                      motor_select_i,
  input  wire logic signed [SPEED_W-1:0] target_speed_i,
  // result items
  output logic                           out_valid_o,
  input  wire logic                      out_ready_i,
  output logic [DUTY_W-1:0]              right_high_duty_o,
  output logic [DUTY_W-1:0]              right_low_duty_o,
  output logic [DUTY_W-1:0]              left_high_duty_o,
  output logic [DUTY_W-1:0]              left_low_duty_o,
  output logic signed [SPEED_W-1:0]      right_command_o,
  output logic signed [SPEED_W-1:0]      left_command_o
);

  logic [RAMP_W-1:0]         ramp_step_q, ramp_step_d;
  logic [OFFSET_W-1:0]       offset_q, offset_d;
  logic                      s1_valid_q, s1_valid_d;
  dmrp_op_e                  s1_op_q;
  dmrp_motor_e               s1_sel_q;
  logic signed [SPEED_W-1:0] s1_tgt_q;
  logic                      res_valid_q, res_valid_d;
  logic                      in_fire;
  logic                      s1_fire;
  logic                      tick_fire;
  dmrp_ctrl_t                ctrl_r, ctrl_l;
  logic signed [SPEED_W-1:0] cmd_r, cmd_l;
  logic [DUTY_W-1:0]         hi_r, lo_r, hi_l, lo_l;

  // configuration register decode
  always_comb begin
    ramp_step_d = ramp_step_q;
    offset_d    = offset_q;
    if (cfg_we_i) begin
      unique case (dmrp_reg_e'(cfg_index_i))
        REG_RAMP_STEP: ramp_step_d = cfg_data_i[RAMP_W-1:0];
        REG_DEADBAND:  offset_d    = cfg_data_i[OFFSET_W-1:0];
        default: ;
      endcase
    end
  end

  // handshake: input register moves on unless a tick would overwrite a waiting result
  always_comb begin
    s1_fire    = s1_valid_q && ((s1_op_q == OP_SET) || !res_valid_q || out_ready_i);
    in_ready_o = !s1_valid_q || s1_fire;
    in_fire    = in_valid_i && in_ready_o;
    tick_fire  = s1_fire && (s1_op_q == OP_TICK);
  end

  // valid flags
  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_fire) begin
      s1_valid_d = 1'b1;
    end else if (s1_fire) begin
      s1_valid_d = 1'b0;
    end
    res_valid_d = res_valid_q;
    if (tick_fire) begin
      res_valid_d = 1'b1;
    end else if (out_ready_i) begin
      res_valid_d = 1'b0;
    end
  end

  // per-motor strobes
  always_comb begin
    ctrl_r.set_en  = s1_fire && (s1_op_q == OP_SET) && (s1_sel_q == MOTOR_RIGHT);
    ctrl_r.tick_en = tick_fire;
    ctrl_l.set_en  = s1_fire && (s1_op_q == OP_SET) && (s1_sel_q == MOTOR_LEFT);
    ctrl_l.tick_en = tick_fire;
  end

  // motor channels
  dmrp_motor u_motor_r (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (ctrl_r),
    .target_i    (s1_tgt_q),
    .ramp_step_i (ramp_step_q),
    .cmd_next_o  (cmd_r)
  );

  dmrp_motor u_motor_l (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (ctrl_l),
    .target_i    (s1_tgt_q),
    .ramp_step_i (ramp_step_q),
    .cmd_next_o  (cmd_l)
  );

  // duty mapping
  dmrp_duty #(
    .DUTY_SCALE (DUTY_SCALE)
  ) u_duty_r (
    .cmd_i    (cmd_r),
    .offset_i (offset_q),
    .high_o   (hi_r),
    .low_o    (lo_r)
  );

  dmrp_duty #(
    .DUTY_SCALE (DUTY_SCALE)
  ) u_duty_l (
    .cmd_i    (cmd_l),
    .offset_i (offset_q),
    .high_o   (hi_l),
    .low_o    (lo_l)
  );

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ramp_step_q <= RAMP_RESET;
      offset_q    <= OFFSET_RESET;
      s1_valid_q  <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      ramp_step_q <= ramp_step_d;
      offset_q    <= offset_d;
      s1_valid_q  <= s1_valid_d;
      res_valid_q <= res_valid_d;
    end
  end

  // input item register
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_op_q  <= dmrp_op_e'(operation_i);
      s1_sel_q <= dmrp_motor_e'(motor_select_i);
      s1_tgt_q <= target_speed_i;
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (tick_fire) begin
      right_high_duty_o <= hi_r;
      right_low_duty_o  <= lo_r;
      left_high_duty_o  <= hi_l;
      left_low_duty_o   <= lo_l;
      right_command_o   <= cmd_r;
      left_command_o    <= cmd_l;
    end
  end

  assign out_valid_o = res_valid_q;

  // checks
  `DMRP_ASSERT_IMP(a_cmd_range, res_valid_q, (right_command_o <= SPEED_LIMIT) && (right_command_o >= -SPEED_LIMIT) && (left_command_o <= SPEED_LIMIT) && (left_command_o >= -SPEED_LIMIT), "command out of range")
  `DMRP_ASSERT_IMP(a_idle_equal, res_valid_q && (right_command_o == '0), right_high_duty_o == right_low_duty_o, "zero command gives unequal duties")
  `DMRP_ASSERT_NXT(a_tick_result, tick_fire, res_valid_q, "tick item gave no result")
  `DMRP_ASSERT_NXT(a_set_silent, s1_fire && (s1_op_q == OP_SET) && (!res_valid_q || out_ready_i), !res_valid_q, "set item gave a result")
  `DMRP_ASSERT_NXT(a_s1_hold, s1_valid_q && !s1_fire, s1_valid_q, "held item lost")

endmodule

`default_nettype wire

[rtl/dmrp_motor.sv]
// one motor channel: target and command store with slew-limited update
`default_nettype none

module dmrp_motor
  import dmrp_pkg::*;
(
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire dmrp_ctrl_t                ctrl_i,
  input  wire logic signed [SPEED_W-1:0] target_i,
  input  wire logic [RAMP_W-1:0]         ramp_step_i,
  output logic signed [SPEED_W-1:0]      cmd_next_o
);

  logic signed [SPEED_W-1:0] target_q, target_d;
  logic signed [SPEED_W-1:0] command_q;
  logic signed [SPEED_W+1:0] diff;
  logic signed [SPEED_W+1:0] step_ext;
  logic signed [SPEED_W+1:0] step_up;
  logic signed [SPEED_W+1:0] step_dn;

  // saturate a new target to the speed range
  always_comb begin
    if (target_i > SPEED_LIMIT) begin
      target_d = SPEED_LIMIT;
    end else if (target_i < -SPEED_LIMIT) begin
      target_d = -SPEED_LIMIT;
    end else begin
      target_d = target_i;
    end
  end

  // move toward the target by at most one step, stopping on it
  always_comb begin
    step_ext = $signed({3'b000, ramp_step_i});
    diff     = 17'(target_q) - 17'(command_q);
    step_up  = 17'(command_q) + step_ext;
    step_dn  = 17'(command_q) - step_ext;
    if (diff > step_ext) begin
      cmd_next_o = step_up[SPEED_W-1:0];
    end else if (diff < -step_ext) begin
      cmd_next_o = step_dn[SPEED_W-1:0];
    end else begin
      cmd_next_o = target_q;
    end
  end

  // state update
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q  <= '0;
      command_q <= '0;
    end else begin
      if (ctrl_i.set_en) begin
        target_q <= target_d;
      end
      if (ctrl_i.tick_en) begin
        command_q <= cmd_next_o;
      end
    end
  end

endmodule

`default_nettype wire

[rtl/dmrp_duty.sv]
// bipolar duty mapping of one motor command onto its bridge sides
`default_nettype none

module dmrp_duty
  import dmrp_pkg::*;
#(
  parameter int DUTY_SCALE = DUTY_SCALE_DEF
) (
  input  wire logic signed [SPEED_W-1:0] cmd_i,
  input  wire logic [OFFSET_W-1:0]       offset_i,
  output logic [DUTY_W-1:0]              high_o,
  output logic [DUTY_W-1:0]              low_o
);

  // scale/100 as one multiply by a rounded-up reciprocal; exact for |cmd| <= 10000
  localparam int RECIP   = (DUTY_SCALE * (2 ** RECIP_SHIFT) + 99) / 100;
  localparam int RECIP_W = $clog2(RECIP + 1);
  localparam int PROD_W  = MAG_W + RECIP_W;
  localparam int Q_W     = $clog2(DUTY_SCALE * 100 + 1);
  localparam int SUM_W   = ((Q_W > OFFSET_W) ? Q_W : OFFSET_W) + 1;

  logic [MAG_W-1:0]  mag;
  logic [SPEED_W-1:0] neg_cmd;
  logic [PROD_W-1:0] prod;
  logic [Q_W-1:0]    scaled;
  logic [SUM_W-1:0]  sum;
  logic [DUTY_W-1:0] driven;
  logic [DUTY_W-1:0] idle;

  // magnitude of the command
  always_comb begin
    neg_cmd = -cmd_i;
    mag     = cmd_i[SPEED_W-1] ? neg_cmd[MAG_W-1:0] : cmd_i[MAG_W-1:0];
  end

  // scale, add offset, saturate
  always_comb begin
    prod   = PROD_W'(mag) * PROD_W'(RECIP);
    scaled = Q_W'(prod >> RECIP_SHIFT);
    sum    = SUM_W'(scaled) + SUM_W'(offset_i);
    driven = (sum > SUM_W'(DUTY_MAX)) ? DUTY_MAX : sum[DUTY_W-1:0];
    idle   = DUTY_W'(offset_i);
  end

  // driven side follows the sign, idle side gets the offset
  assign high_o = (!cmd_i[SPEED_W-1] && (cmd_i != '0)) ? driven : idle;
  assign low_o  = cmd_i[SPEED_W-1] ? driven : idle;

endmodule

`default_nettype wire
